@@ rtl/lrod_pkg.sv @@
// Package for the LZSS ring/distance decoder.
// Shared constants, result codes, register indexes and FSM state type.
// No dependencies.
`default_nettype none

package lrod_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_W       = $clog2(WINDOW_SIZE);
    localparam int COUNT_WIDTH = 24;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_MATCH = 2'd2
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAP   = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_LIT  = 3'd1,
        S_CRD  = 3'd2,
        S_CWR  = 3'd3,
        S_FIN  = 3'd4
    } state_t;

endpackage

`default_nettype wire

@@ rtl/lzss_ring_or_distance_decoder_top.sv @@
// LZSS decompressor with 4 KiB history, ring or backward-distance addressing.
// A literal result is loaded from S_LIT after its byte is accepted; a match copies
// each byte by a history read (S_CRD), then write-back (S_CWR) that waits for the output,
// through the single-port history memory. The next item is taken once all results are queued.
// Reset: control state cleared; history is not swept, a fill count gates reads.
// Depends on lrod_pkg.
`default_nettype none

module lzss_ring_or_distance_decoder_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [7:0]                            in_byte,
    input  wire logic                                  stream_first,
    input  wire logic                                  stream_last,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [1:0]                                 kind,
    output logic [7:0]                                 out_byte,
    output logic [lrod_pkg::COUNT_WIDTH-1:0]           written_count,
    output logic                                       last_of_run,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lrod_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [lrod_pkg::COUNT_WIDTH-1:0]      cfg_data
);

    localparam int CW = lrod_pkg::COUNT_WIDTH;
    localparam int AW = lrod_pkg::WIN_W;
    localparam int LW = lrod_pkg::LEN_W;

    lrod_pkg::state_t state_reg, state_next;
    lrod_pkg::phase_t phase_reg, phase_next;
    lrod_pkg::kind_t  fin_kind_reg, fin_kind_next;
    lrod_pkg::kind_t  kind_reg, kind_next;

    logic          ring_mode_reg;
    logic [CW-1:0] cap_reg;
    logic [7:0]    flag_reg, flag_next;
    logic [3:0]    bits_reg, bits_next;
    logic [7:0]    hi_reg, hi_next;
    logic [CW-1:0] bytes_reg, bytes_next;
    logic          stopped_reg, stopped_next;
    logic          full_reg, full_next;
    logic          err_pend_reg, err_pend_next;
    logic [7:0]    lit_reg, lit_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [7:0]    rd_q_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [CW-1:0] count_reg, count_next;
    logic          last_reg, last_next;

    logic          in_fire, can_push, rd_en, wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic [7:0]    e_flag;
    logic [3:0]    e_bits, nb_bits;
    logic [CW-1:0] e_bytes;
    logic          e_stopped, fail, is_term;
    logic [AW-1:0] m_addr;
    logic [LW-1:0] m_len;
    logic [CW:0]   m_end;
    logic [7:0]    cp_val;

    logic [7:0]    hist_mem [lrod_pkg::WINDOW_SIZE];

    assign in_ready      = (state_reg == lrod_pkg::S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign cfg_ready     = 1'b1;
    assign can_push      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_byte      = out_byte_reg;
    assign written_count = count_reg;
    assign last_of_run   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_mode_reg <= 1'b1;
            cap_reg       <= {CW{1'b1}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lrod_pkg::CFG_RING_MODE: ring_mode_reg <= cfg_data[0];
                lrod_pkg::CFG_OUT_CAP:   cap_reg       <= cfg_data;
                default:                 cap_reg       <= cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= hist_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrod_pkg::S_IDLE;
            phase_reg     <= lrod_pkg::PH_FLAG;
            fin_kind_reg  <= lrod_pkg::KIND_ERR;
            kind_reg      <= lrod_pkg::KIND_DATA;
            flag_reg      <= '0;
            bits_reg      <= '0;
            hi_reg        <= '0;
            bytes_reg     <= '0;
            stopped_reg   <= 1'b0;
            full_reg      <= 1'b0;
            err_pend_reg  <= 1'b0;
            cnt_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fin_kind_reg  <= fin_kind_next;
            kind_reg      <= kind_next;
            flag_reg      <= flag_next;
            bits_reg      <= bits_next;
            hi_reg        <= hi_next;
            bytes_reg     <= bytes_next;
            stopped_reg   <= stopped_next;
            full_reg      <= full_next;
            err_pend_reg  <= err_pend_next;
            cnt_reg       <= cnt_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        ptr_reg      <= ptr_next;
        out_byte_reg <= out_byte_next;
        count_reg    <= count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fin_kind_next  = fin_kind_reg;
        kind_next      = kind_reg;
        flag_next      = flag_reg;
        bits_next      = bits_reg;
        hi_next        = hi_reg;
        bytes_next     = bytes_reg;
        stopped_next   = stopped_reg;
        full_next      = full_reg || (bytes_reg[CW-1:AW] != '0);
        err_pend_next  = err_pend_reg;
        lit_next       = lit_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = bytes_reg[AW-1:0] + AW'(1);
        wr_data        = lit_reg;
        fail           = 1'b0;
        is_term        = 1'b0;

        e_flag    = stream_first ? 8'd0 : flag_reg;
        e_bits    = stream_first ? 4'd0 : bits_reg;
        e_bytes   = stream_first ? '0 : bytes_reg;
        e_stopped = stream_first ? 1'b0 : stopped_reg;
        nb_bits   = (e_bits != 4'd0) ? e_bits - 4'd1 : 4'd0;
        m_addr    = {hi_reg[7:4], in_byte};
        m_len     = LW'(hi_reg[3:0]) + LW'(2);
        m_end     = {1'b0, e_bytes} + (CW+1)'(m_len);
        cp_val    = rd_ok_reg ? rd_q_reg : 8'd0;

        case (state_reg)
            lrod_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (stream_first)
                    begin
                        phase_next    = lrod_pkg::PH_FLAG;
                        flag_next     = '0;
                        bits_next     = '0;
                        hi_next       = '0;
                        bytes_next    = '0;
                        stopped_next  = 1'b0;
                        full_next     = 1'b0;
                    end
                    err_pend_next = 1'b0;
                    if (!e_stopped)
                    begin
                        case (stream_first ? lrod_pkg::PH_FLAG : phase_reg)
                            lrod_pkg::PH_TOKEN:
                            begin
                                if (e_flag[0])
                                begin
                                    if (e_bytes >= cap_reg)
                                    begin
                                        fail = 1'b1;
                                    end
                                    else
                                    begin
                                        lit_next   = in_byte;
                                        state_next = lrod_pkg::S_LIT;
                                        flag_next  = {1'b0, e_flag[7:1]};
                                        bits_next  = nb_bits;
                                        phase_next = (nb_bits == 4'd0) ? lrod_pkg::PH_FLAG
                                                                        : lrod_pkg::PH_TOKEN;
                                    end
                                end
                                else
                                begin
                                    hi_next    = in_byte;
                                    phase_next = lrod_pkg::PH_MATCH;
                                end
                            end
                            lrod_pkg::PH_MATCH:
                            begin
                                if (m_addr == '0 && hi_reg[3:0] == 4'd0)
                                begin
                                    is_term       = 1'b1;
                                    fin_kind_next = lrod_pkg::KIND_DONE;
                                    stopped_next  = 1'b1;
                                    state_next    = lrod_pkg::S_FIN;
                                end
                                else if ((e_bytes <= cap_reg && m_end > {1'b0, cap_reg})
                                         || (!ring_mode_reg && (m_addr == '0
                                         || {{(CW-AW){1'b0}}, m_addr} > e_bytes)))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    ptr_next   = ring_mode_reg ? m_addr
                                               : e_bytes[AW-1:0] + AW'(1) - m_addr;
                                    cnt_next   = m_len;
                                    state_next = lrod_pkg::S_CRD;
                                    flag_next  = {1'b0, e_flag[7:1]};
                                    bits_next  = nb_bits;
                                    phase_next = (nb_bits == 4'd0) ? lrod_pkg::PH_FLAG
                                                                    : lrod_pkg::PH_TOKEN;
                                end
                            end
                            default:
                            begin
                                flag_next  = in_byte;
                                bits_next  = 4'd8;
                                phase_next = lrod_pkg::PH_TOKEN;
                            end
                        endcase
                        if (!is_term && (fail || stream_last))
                        begin
                            fin_kind_next = lrod_pkg::KIND_ERR;
                            stopped_next  = 1'b1;
                            if (fail)
                            begin
                                state_next = lrod_pkg::S_FIN;
                            end
                            else if (state_next == lrod_pkg::S_IDLE)
                            begin
                                state_next = lrod_pkg::S_FIN;
                            end
                            else
                            begin
                                err_pend_next = 1'b1;
                            end
                        end
                    end
                end
            end
            lrod_pkg::S_LIT:
            begin
                if (can_push)
                begin
                    wr_en          = 1'b1;
                    wr_data        = lit_reg;
                    bytes_next     = bytes_reg + CW'(1);
                    out_valid_next = 1'b1;
                    kind_next      = lrod_pkg::KIND_DATA;
                    out_byte_next  = lit_reg;
                    count_next     = bytes_reg + CW'(1);
                    last_next      = !err_pend_reg;
                    state_next     = err_pend_reg ? lrod_pkg::S_FIN : lrod_pkg::S_IDLE;
                end
            end
            lrod_pkg::S_CRD:
            begin
                rd_en      = 1'b1;
                rd_ok_next = full_reg || (bytes_reg[CW-1:AW] != '0)
                          || (ptr_reg != '0 && bytes_reg >= {{(CW-AW){1'b0}}, ptr_reg});
                state_next = lrod_pkg::S_CWR;
            end
            lrod_pkg::S_CWR:
            begin
                if (can_push)
                begin
                    wr_en          = 1'b1;
                    wr_data        = cp_val;
                    bytes_next     = bytes_reg + CW'(1);
                    ptr_next       = ptr_reg + AW'(1);
                    cnt_next       = cnt_reg - LW'(1);
                    out_valid_next = 1'b1;
                    kind_next      = lrod_pkg::KIND_DATA;
                    out_byte_next  = cp_val;
                    count_next     = bytes_reg + CW'(1);
                    if (cnt_reg == LW'(1))
                    begin
                        last_next  = !err_pend_reg;
                        state_next = err_pend_reg ? lrod_pkg::S_FIN : lrod_pkg::S_IDLE;
                    end
                    else
                    begin
                        last_next  = 1'b0;
                        state_next = lrod_pkg::S_CRD;
                    end
                end
            end
            lrod_pkg::S_FIN:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = fin_kind_reg;
                    out_byte_next  = 8'd0;
                    count_next     = bytes_reg;
                    last_next      = 1'b1;
                    state_next     = lrod_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lrod_pkg::S_IDLE;
            end
        endcase
    end

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrod_pkg::S_CRD |=> state_reg == lrod_pkg::S_CWR)
        else $error("copy read not followed by write-back");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lrod_pkg::S_CRD |-> cnt_reg != '0)
        else $error("copy read with no bytes left");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != lrod_pkg::KIND_DATA |-> last_reg)
        else $error("finish or error result not last of run");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en && !(in_fire && stream_first) |=> $stable(bytes_reg))
        else $error("byte count moved without a history write");

endmodule

`default_nettype wire
